>>> rtl/rmer_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmer_pkg
// Shared constants and register indexes for the rotated ellipse rasterizer.
// ----------------------------------------------------------------------------
package rmer_pkg;

    localparam int RADIUS_BITS    = 10;
    localparam int COORD_BITS     = 12;
    localparam int TRIG_FRAC_BITS = 14;
    localparam int TRIG_W         = TRIG_FRAC_BITS + 2;
    localparam int PIX_W          = 14;
    localparam int HALF_W         = 11;
    localparam int COLOR_W        = 4;
    localparam int CFG_DATA_W     = TRIG_W;
    localparam int CFG_IDX_W      = 3;
    localparam int WALK_W         = RADIUS_BITS + 1;
    localparam int SLOPE_W        = 4 * RADIUS_BITS + 4;
    localparam int DEC_W          = 4 * RADIUS_BITS + 10;
    localparam int MUL_W          = 2 * RADIUS_BITS + 4;
    localparam int PT_W           = COORD_BITS + 3;
    localparam int PROD_W         = PT_W + TRIG_W;
    localparam int ROT_W          = PROD_W + 1;

    localparam logic [CFG_IDX_W-1:0] REG_COS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHX    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHY    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HALFW  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HALFH  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR  = 3'd6;

    localparam logic [PIX_W-1:0] PIX_MAX = {1'b0, {(PIX_W-1){1'b1}}};
    localparam logic [PIX_W-1:0] PIX_MIN = {1'b1, {(PIX_W-1){1'b0}}};

endpackage

>>> rtl/rotated_midpoint_ellipse_rasterizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotated_midpoint_ellipse_rasterizer
// Midpoint ellipse walk with rotation and screen mapping, one shared multiplier.
// ----------------------------------------------------------------------------
// Start item: setup micro-ops and a finish state, no result; when the walk begins in region two,
// the R2 multiplier ops and another finish follow before the block is ready again.
// Step item: each of 4 pixels takes PLOT multiplier ops and an EMIT state, then an update and
// a finish state; R2 is added on a region change, and EMIT waits while the output stalls.
// A step when idle is accepted and produces no pixel.
// One item at a time through the shared multiplier. Async active-low reset clears the walk.
module rotated_midpoint_ellipse_rasterizer (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [rmer_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [rmer_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  func,
    input  logic [rmer_pkg::RADIUS_BITS-1:0]      radius_x,
    input  logic [rmer_pkg::RADIUS_BITS-1:0]      radius_y,
    input  logic signed [rmer_pkg::COORD_BITS-1:0] center_x,
    input  logic signed [rmer_pkg::COORD_BITS-1:0] center_y,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [rmer_pkg::PIX_W-1:0]     pixel_x,
    output logic signed [rmer_pkg::PIX_W-1:0]     pixel_y,
    output logic [rmer_pkg::COLOR_W-1:0]          color,
    output logic [1:0]                            quadrant,
    output logic                                  last_of_step,
    output logic                                  ellipse_done
);

    localparam int DW = rmer_pkg::DEC_W;
    localparam int RW = rmer_pkg::ROT_W;

    // Sequencer states. SETUP, PLOT and R2 issue one product per cycle on the
    // shared multiplier; the micro-op counter selects operands and destination.
    // EMIT hands a finished pixel to the output register.
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SETUP = 7'b0000010,
        S_PLOT  = 7'b0000100,
        S_EMIT  = 7'b0001000,
        S_UPD   = 7'b0010000,
        S_R2    = 7'b0100000,
        S_FIN   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // Configuration.
    logic signed [rmer_pkg::TRIG_W-1:0]     cos_reg, sin_reg;
    logic signed [rmer_pkg::COORD_BITS-1:0] shx_reg, shy_reg;
    logic [rmer_pkg::HALF_W-1:0]            halfw_reg, halfh_reg;
    logic [rmer_pkg::COLOR_W-1:0]           pcolor_reg;

    // Walk state.
    logic                                   active_reg, r2_reg;
    logic signed [rmer_pkg::WALK_W:0]       wx_reg, wy_reg;
    logic signed [DW-1:0]                   sdx_reg, sdy_reg, dec_reg;
    logic [rmer_pkg::RADIUS_BITS-1:0]       rx_reg, ry_reg;
    logic signed [rmer_pkg::COORD_BITS-1:0] cx_reg, cy_reg;

    // Scratch: rx^2, ry^2, accumulator, op counter.
    logic signed [DW-1:0] rx2_reg, ry2_reg, acc_reg;
    logic [3:0]           op_reg;
    logic [1:0]           k_reg;
    logic                 done_reg;

    // The shared multiplier: one signed product per cycle, registered.
    logic signed [RW-1:0] ma, mb;
    logic signed [DW-1:0] prod_reg;
    logic signed [RW+RW-1:0] mfull;

    // Working pixel and output register.
    logic signed [rmer_pkg::PIX_W-1:0] px_reg, py_reg;
    logic                              ov_reg;
    logic signed [rmer_pkg::PIX_W-1:0] opx_reg, opy_reg;
    logic [1:0]                        q_reg;
    logic                              last_reg, odone_reg;
    logic [rmer_pkg::COLOR_W-1:0]      col_reg;

    // Point for the current quadrant.
    logic signed [rmer_pkg::PT_W-1:0] bx, by, ptx, pty;
    logic signed [RW-1:0] rot_q;
    logic signed [RW:0]   scr;
    logic signed [DW-1:0] rot_sum;

    always_comb
    begin
        bx = rmer_pkg::PT_W'(cx_reg) + rmer_pkg::PT_W'(shx_reg);
        by = rmer_pkg::PT_W'(cy_reg) + rmer_pkg::PT_W'(shy_reg);
        ptx = k_reg[0] ? bx - rmer_pkg::PT_W'(wx_reg) : bx + rmer_pkg::PT_W'(wx_reg);
        pty = k_reg[1] ? by - rmer_pkg::PT_W'(wy_reg) : by + rmer_pkg::PT_W'(wy_reg);
    end

    assign in_ready = (state_reg == S_IDLE);
    assign mfull    = ma * mb;

    // Operand select for the multiplier.
    always_comb
    begin
        ma = '0;
        mb = '0;
        unique case (state_reg)
            S_SETUP:
            begin
                case (op_reg)
                    4'd0:
                    begin
                        ma = RW'(rx_reg);
                        mb = RW'(rx_reg);
                    end
                    4'd1:
                    begin
                        ma = RW'(ry_reg);
                        mb = RW'(ry_reg);
                    end
                    default:
                    begin
                        ma = RW'(rx2_reg);
                        mb = RW'(ry_reg);
                    end
                endcase
            end
            S_PLOT:
            begin
                case (op_reg)
                    4'd0:
                    begin
                        ma = RW'(ptx);
                        mb = RW'(cos_reg);
                    end
                    4'd1:
                    begin
                        ma = RW'(pty);
                        mb = RW'(sin_reg);
                    end
                    4'd2:
                    begin
                        ma = RW'(pty);
                        mb = RW'(cos_reg);
                    end
                    default:
                    begin
                        ma = RW'(ptx);
                        mb = RW'(sin_reg);
                    end
                endcase
            end
            S_R2:
            begin
                // squares come straight from the product register
                case (op_reg)
                    4'd0:
                    begin
                        ma = RW'(2 * wx_reg + 1);
                        mb = RW'(2 * wx_reg + 1);
                    end
                    4'd1:
                    begin
                        ma = RW'(prod_reg);
                        mb = RW'(ry2_reg);
                    end
                    4'd2:
                    begin
                        ma = RW'(wy_reg - 1);
                        mb = RW'(wy_reg - 1);
                    end
                    4'd3:
                    begin
                        ma = RW'(prod_reg);
                        mb = RW'(rx2_reg);
                    end
                    default:
                    begin
                        ma = RW'(rx2_reg);
                        mb = RW'(ry2_reg);
                    end
                endcase
            end
            default: ;
        endcase
    end

    // Op 2 forms x*cos - y*sin, op 4 forms y*cos + x*sin; truncate toward zero.
    always_comb
    begin
        rot_sum = (op_reg[2] ? acc_reg + prod_reg : acc_reg - prod_reg);
        rot_q   = RW'(rot_sum >>> rmer_pkg::TRIG_FRAC_BITS);
        if (rot_sum < 0 && rot_sum[rmer_pkg::TRIG_FRAC_BITS-1:0] != '0)
            rot_q = rot_q + 1'b1;
        if (!op_reg[2])
            scr = (RW+1)'(rot_q) + (RW+1)'(halfw_reg);
        else
            scr = (RW+1)'(halfh_reg) - (RW+1)'(rot_q);
    end

    function automatic logic [rmer_pkg::PIX_W-1:0] sat(input logic signed [RW:0] v);
        if (v > (RW+1)'(signed'(rmer_pkg::PIX_MAX)))
            return rmer_pkg::PIX_MAX;
        else if (v < (RW+1)'(signed'(rmer_pkg::PIX_MIN)))
            return rmer_pkg::PIX_MIN;
        else
            return v[rmer_pkg::PIX_W-1:0];
    endfunction

    // Config registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_reg    <= 16'sd16384;
            sin_reg    <= '0;
            shx_reg    <= '0;
            shy_reg    <= '0;
            halfw_reg  <= 11'd320;
            halfh_reg  <= 11'd240;
            pcolor_reg <= 4'd15;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rmer_pkg::REG_COS:   cos_reg    <= cfg_data;
                rmer_pkg::REG_SIN:   sin_reg    <= cfg_data;
                rmer_pkg::REG_SHX:   shx_reg    <= cfg_data[rmer_pkg::COORD_BITS-1:0];
                rmer_pkg::REG_SHY:   shy_reg    <= cfg_data[rmer_pkg::COORD_BITS-1:0];
                rmer_pkg::REG_HALFW: halfw_reg  <= cfg_data[rmer_pkg::HALF_W-1:0];
                rmer_pkg::REG_HALFH: halfh_reg  <= cfg_data[rmer_pkg::HALF_W-1:0];
                rmer_pkg::REG_COLOR: pcolor_reg <= cfg_data[rmer_pkg::COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    // Multiplier output register.
    always_ff @(posedge clk)
    begin
        prod_reg <= DW'(mfull);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                    state_next = !func ? S_SETUP : (active_reg ? S_PLOT : S_IDLE);
            S_SETUP: if (op_reg == 4'd6) state_next = S_FIN;
            S_PLOT:  if (op_reg == 4'd4) state_next = S_EMIT;
            S_EMIT:
                if (!ov_reg || out_ready)
                    state_next = (k_reg == 2'd3) ? S_UPD : S_PLOT;
            S_UPD:   state_next = S_FIN;
            S_R2:    if (op_reg == 4'd7) state_next = S_FIN;
            S_FIN:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
        // leave FIN for region two if the slope test flips
        if (state_reg == S_FIN && !r2_reg && !(sdx_reg < sdy_reg))
            state_next = S_R2;
    end

    // Datapath and control. Micro-ops in setup: rx^2, ry^2, rx^2*ry.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            active_reg <= 1'b0;
            r2_reg     <= 1'b0;
            op_reg     <= '0;
            k_reg      <= '0;
            ov_reg     <= 1'b0;
            done_reg   <= 1'b0;
            rx_reg     <= '0;
            ry_reg     <= '0;
            cx_reg     <= '0;
            cy_reg     <= '0;
            wx_reg     <= '0;
            wy_reg     <= '0;
            sdx_reg    <= '0;
            sdy_reg    <= '0;
            dec_reg    <= '0;
            rx2_reg    <= '0;
            ry2_reg    <= '0;
            acc_reg    <= '0;
            px_reg     <= '0;
            py_reg     <= '0;
            opx_reg    <= '0;
            opy_reg    <= '0;
            q_reg      <= '0;
            last_reg   <= 1'b0;
            odone_reg  <= 1'b0;
            col_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            // load a pixel when the output register frees up, else drop it on transfer
            if (state_reg == S_EMIT && (!ov_reg || out_ready))
                ov_reg <= 1'b1;
            else if (ov_reg && out_ready)
                ov_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    op_reg <= '0;
                    k_reg  <= '0;
                    if (in_valid && !func)
                    begin
                        rx_reg <= radius_x;
                        ry_reg <= radius_y;
                        cx_reg <= center_x;
                        cy_reg <= center_y;
                        r2_reg <= 1'b0;
                        active_reg <= 1'b1;
                    end
                end
                S_SETUP:
                begin
                    op_reg <= op_reg + 1'b1;
                    // product of op n is ready at op n+1
                    if (op_reg == 4'd1) rx2_reg <= prod_reg;
                    if (op_reg == 4'd2) ry2_reg <= prod_reg;
                    if (op_reg == 4'd3)
                    begin
                        wx_reg  <= '0;
                        wy_reg  <= (rmer_pkg::WALK_W+1)'(ry_reg);
                        sdx_reg <= '0;
                        sdy_reg <= prod_reg <<< 1;
                        dec_reg <= (ry2_reg <<< 2) - (prod_reg <<< 2) + rx2_reg;
                    end
                end
                S_PLOT:
                begin
                    op_reg <= op_reg + 1'b1;
                    case (op_reg)
                        4'd1: acc_reg <= prod_reg;
                        4'd2:
                        begin
                            px_reg  <= sat(scr);
                        end
                        4'd3: acc_reg <= prod_reg;
                        4'd4:
                        begin
                            py_reg <= sat(scr);
                        end
                        default: ;
                    endcase
                end
                S_EMIT:
                begin
                    if (!ov_reg || out_ready)
                    begin
                        opx_reg   <= px_reg;
                        opy_reg   <= py_reg;
                        q_reg     <= k_reg;
                        last_reg  <= (k_reg == 2'd3);
                        col_reg   <= pcolor_reg;
                        // the step ends the walk when region two takes y below zero
                        odone_reg <= r2_reg && (wy_reg == '0);
                        k_reg     <= k_reg + 1'b1;
                        op_reg    <= '0;
                    end
                end
                S_UPD:
                begin
                    if (!r2_reg)
                    begin
                        wx_reg  <= wx_reg + 1'b1;
                        sdx_reg <= sdx_reg + (ry2_reg <<< 1);
                        if (dec_reg < 0)
                            dec_reg <= dec_reg + ((sdx_reg + (ry2_reg <<< 1) + ry2_reg) <<< 2);
                        else
                        begin
                            wy_reg  <= wy_reg - 1'b1;
                            sdy_reg <= sdy_reg - (rx2_reg <<< 1);
                            dec_reg <= dec_reg + ((sdx_reg + (ry2_reg <<< 1)
                                       - sdy_reg + (rx2_reg <<< 1) + ry2_reg) <<< 2);
                        end
                    end
                    else
                    begin
                        wy_reg  <= wy_reg - 1'b1;
                        sdy_reg <= sdy_reg - (rx2_reg <<< 1);
                        if (dec_reg > 0)
                            dec_reg <= dec_reg + ((rx2_reg - sdy_reg + (rx2_reg <<< 1)) <<< 2);
                        else
                        begin
                            wx_reg  <= wx_reg + 1'b1;
                            sdx_reg <= sdx_reg + (ry2_reg <<< 1);
                            dec_reg <= dec_reg + ((sdx_reg + (ry2_reg <<< 1) - sdy_reg
                                       + (rx2_reg <<< 1) + rx2_reg) <<< 2);
                        end
                    end
                    done_reg <= 1'b1;
                    op_reg   <= '0;
                end
                S_R2:
                begin
                    // tx^2*ry2 + 4*ty^2*rx2 - 4*rx2*ry2
                    op_reg <= op_reg + 1'b1;
                    case (op_reg)
                        4'd2: acc_reg <= prod_reg;
                        4'd4: acc_reg <= acc_reg + (prod_reg <<< 2);
                        4'd6: dec_reg <= acc_reg - (prod_reg <<< 2);
                        4'd7: r2_reg  <= 1'b1;
                        default: ;
                    endcase
                end
                S_FIN:
                begin
                    op_reg <= '0;
                    if (done_reg && r2_reg && wy_reg < 0)
                        active_reg <= 1'b0;
                    done_reg <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    assign out_valid    = ov_reg;
    assign pixel_x      = opx_reg;
    assign pixel_y      = opy_reg;
    assign color        = col_reg;
    assign quadrant     = q_reg;
    assign last_of_step = last_reg;
    assign ellipse_done = odone_reg;

`ifndef SYNTH
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (state_reg == S_IDLE)) else $error("ready outside idle");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !out_ready) |=> ov_reg) else $error("output dropped");
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !out_ready) |=> ($stable(opx_reg) && $stable(opy_reg)))
        else $error("output payload changed while waiting");
    a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg)) else $error("state not one-hot");
`endif

endmodule
